### sv/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] ATTR_PUT     = 8'h07;
    localparam logic [7:0] ATTR_CLEAR   = 8'h0F;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP
    } state_t;

endpackage

### sv/text_console_writer_top.sv
`timescale 1ns / 1ps

// Text console engine: a ROWS x COLUMNS grid of 16-bit cells (attribute in the high byte,
// character in the low byte) kept in one synchronous RAM, plus a cursor. Each request
// returns exactly one response carrying the cell read (reads only), the cursor after the
// request and a scroll flag. A put that does not scroll, or an unused command, is answered
// straight from the idle state; a read first passes the registered RAM read and a read
// state. A clear, or a put that scrolls, sweeps the RAM through its single write port one
// cell per cycle, and the next request is taken only after every cell has been written;
// the response is already available during that sweep. After reset the same sweep writes
// zeros to every cell before the first request is taken.
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cmd[1:0], char_code[9:2], cell_index[20:10], zero fill above.
    input  logic [tcw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // cell_data[15:0], cursor_column[22:16], cursor_row[27:23], scrolled[28], zero above.
    output logic [tcw_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    logic [tcw_pkg::CELL_W-1:0] mem [CELL_COUNT];

    tcw_pkg::state_t state_reg, state_next;

    logic [CELL_AW-1:0]              sweep_reg, sweep_next;
    logic                            copy_mode_reg, copy_mode_next;
    logic [tcw_pkg::CELL_W-1:0]      fill_reg, fill_next;
    logic                            wr_pend_reg, wr_pend_next;
    logic [CELL_AW-1:0]              wr_addr_reg, wr_addr_next;
    logic                            wr_copy_reg, wr_copy_next;
    logic [tcw_pkg::CELL_W-1:0]      rd_data_reg;
    logic                            read_ok_reg, read_ok_next;

    logic [tcw_pkg::COL_W-1:0]       cursor_col_reg, cursor_col_next;
    logic [tcw_pkg::ROW_W-1:0]       cursor_line_reg, cursor_line_next;

    logic                            out_valid_reg, out_valid_next;
    logic [tcw_pkg::CELL_W-1:0]      out_data_reg, out_data_next;
    logic [tcw_pkg::COL_W-1:0]       out_col_reg, out_col_next;
    logic [tcw_pkg::ROW_W-1:0]       out_row_reg, out_row_next;
    logic                            out_scrolled_reg, out_scrolled_next;

    logic                            mem_we;
    logic [CELL_AW-1:0]              mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]      mem_wdata;
    logic [CELL_AW-1:0]              mem_raddr;

    logic                            accept;
    tcw_pkg::cmd_t                   in_cmd;
    logic [tcw_pkg::CHAR_W-1:0]      in_char;
    logic [12:0]                     in_index;
    logic [12:0]                     sweep_ext;
    logic [12:0]                     copy_src;
    logic                            copy_ok;
    logic [11:0]                     put_idx;
    logic [7:0]                      col_inc;
    logic [5:0]                      line_inc;
    logic [5:0]                      line_new;
    logic [tcw_pkg::COL_W-1:0]       col_new;
    logic                            is_newline;

    assign in_cmd    = tcw_pkg::cmd_t'(s_axis_tdata[1:0]);
    assign in_char   = s_axis_tdata[9:2];
    assign in_index  = 13'(s_axis_tdata[20:10]);
    assign sweep_ext = 13'(sweep_reg);
    assign copy_src  = sweep_ext + 13'(COLUMNS);
    assign copy_ok   = copy_mode_reg && (sweep_ext < 13'(CELL_COUNT - COLUMNS));
    assign put_idx   = 12'(cursor_line_reg) * 12'(COLUMNS) + 12'(cursor_col_reg);
    assign col_inc   = {1'b0, cursor_col_reg} + 8'd1;
    assign line_inc  = {1'b0, cursor_line_reg} + 6'd1;
    assign is_newline = (in_char == tcw_pkg::NEWLINE_CODE);

    assign s_axis_tready = (state_reg == tcw_pkg::ST_IDLE) && !wr_pend_reg
                           && (!out_valid_reg || m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_scrolled_reg, out_row_reg, out_col_reg, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tcw_pkg::ST_SWEEP;
            sweep_reg       <= '0;
            copy_mode_reg   <= 1'b0;
            fill_reg        <= '0;
            wr_pend_reg     <= 1'b0;
            cursor_col_reg  <= '0;
            cursor_line_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            copy_mode_reg   <= copy_mode_next;
            fill_reg        <= fill_next;
            wr_pend_reg     <= wr_pend_next;
            cursor_col_reg  <= cursor_col_next;
            cursor_line_reg <= cursor_line_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg      <= wr_addr_next;
        wr_copy_reg      <= wr_copy_next;
        read_ok_reg      <= read_ok_next;
        out_data_reg     <= out_data_next;
        out_col_reg      <= out_col_next;
        out_row_reg      <= out_row_next;
        out_scrolled_reg <= out_scrolled_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        copy_mode_next    = copy_mode_reg;
        fill_next         = fill_reg;
        wr_pend_next      = (state_reg == tcw_pkg::ST_SWEEP);
        wr_addr_next      = sweep_reg;
        wr_copy_next      = copy_ok;
        read_ok_next      = read_ok_reg;
        cursor_col_next   = cursor_col_reg;
        cursor_line_next  = cursor_line_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_data_next     = out_data_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        out_scrolled_next = out_scrolled_reg;
        line_new          = {1'b0, cursor_line_reg};
        col_new           = cursor_col_reg;

        mem_we    = wr_pend_reg;
        mem_waddr = wr_addr_reg;
        mem_wdata = wr_copy_reg ? rd_data_reg : fill_reg;
        mem_raddr = (state_reg == tcw_pkg::ST_SWEEP) ? copy_src[CELL_AW-1:0]
                                                     : in_index[CELL_AW-1:0];

        case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next    = 1'b1;
                    out_data_next     = '0;
                    out_col_next      = cursor_col_reg;
                    out_row_next      = cursor_line_reg;
                    out_scrolled_next = 1'b0;
                    case (in_cmd)
                        tcw_pkg::CMD_PUT:
                        begin
                            if (is_newline)
                            begin
                                col_new  = '0;
                                line_new = line_inc;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = put_idx[CELL_AW-1:0];
                                mem_wdata = {tcw_pkg::ATTR_PUT, in_char};
                                if (col_inc >= 8'(COLUMNS))
                                begin
                                    col_new  = '0;
                                    line_new = line_inc;
                                end
                                else
                                begin
                                    col_new = col_inc[tcw_pkg::COL_W-1:0];
                                end
                            end
                            if (line_new >= 6'(ROWS))
                            begin
                                line_new          = 6'(ROWS - 1);
                                out_scrolled_next = 1'b1;
                                state_next        = tcw_pkg::ST_SWEEP;
                                sweep_next        = '0;
                                copy_mode_next    = 1'b1;
                                fill_next         = {tcw_pkg::ATTR_PUT, tcw_pkg::SPACE_CODE};
                            end
                            cursor_col_next  = col_new;
                            cursor_line_next = line_new[tcw_pkg::ROW_W-1:0];
                            out_col_next     = col_new;
                            out_row_next     = line_new[tcw_pkg::ROW_W-1:0];
                        end
                        tcw_pkg::CMD_CLEAR:
                        begin
                            cursor_col_next  = '0;
                            cursor_line_next = '0;
                            out_col_next     = '0;
                            out_row_next     = '0;
                            state_next       = tcw_pkg::ST_SWEEP;
                            sweep_next       = '0;
                            copy_mode_next   = 1'b0;
                            fill_next        = {tcw_pkg::ATTR_CLEAR, tcw_pkg::SPACE_CODE};
                        end
                        tcw_pkg::CMD_READ:
                        begin
                            out_valid_next = 1'b0;
                            read_ok_next   = (in_index < 13'(CELL_COUNT));
                            state_next     = tcw_pkg::ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ:
            begin
                out_valid_next    = 1'b1;
                out_data_next     = read_ok_reg ? rd_data_reg : '0;
                out_col_next      = cursor_col_reg;
                out_row_next      = cursor_line_reg;
                out_scrolled_next = 1'b0;
                state_next        = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_SWEEP:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == CELL_AW'(CELL_COUNT - 1))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cursor_col_reg) < COLUMNS) && (32'(cursor_line_reg) < ROWS))
        else $error("cursor left the screen");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcw_pkg::ST_READ) |-> !out_valid_reg)
        else $error("read data arrived while the output register was full");

    a_sweep_tail_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcw_pkg::ST_SWEEP) |=> wr_pend_reg)
        else $error("sweep issued a cell without a following write");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !wr_pend_reg && (state_reg == tcw_pkg::ST_IDLE))
        else $error("request taken while the sweep still owns the write port");

endmodule
